### src/mdr_pkg.sv
// Shared types, constants and helpers of the mixture density relaxation block.
package mdr_pkg;

   // Fraction fields carried by one word, and the stream limit of the scheme
   localparam int MAX_MIX   = 2;
   localparam int NUM_FRAC  = 2;
   localparam int USED_MAX  = (MAX_MIX < NUM_FRAC) ? MAX_MIX : NUM_FRAC;

   // Datapath widths
   localparam int QUO_W  = 32;   // quotient bits of the reciprocal
   localparam int DEN_W  = 50;   // positive inverse density
   localparam int INV_W  = 51;   // signed inverse density
   localparam int PROD_W = 48;   // Q1.15 times Q16.16 product
   localparam int FSUM_W = 18;   // sum of the fraction fields
   localparam int NUM_DIV_CELLS = QUO_W;

   localparam logic [15:0] Q15_ONE    = 16'h8000;
   localparam logic [15:0] ROUND_HALF = 16'h4000;
   localparam logic [DEN_W-1:0] RECIP_NUM = DEN_W'(64'h0000_8000_0000_0000);

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_MIXING_COUNT     = 3'd0,
      CSR_INV_DENSITY_0    = 3'd1,
      CSR_INV_DENSITY_1    = 3'd2,
      CSR_INV_DENSITY_REST = 3'd3,
      CSR_RELAX_FACTOR     = 3'd4,
      CSR_WALL_TYPE        = 3'd5,
      CSR_SKIP_WALLS       = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] mix_frac_0;
      logic [15:0] mix_frac_1;
      logic [31:0] old_density;
      logic [7:0]  cell_kind;
   } req_type;

   typedef struct packed {
      logic [31:0] relaxed_den;
      logic        density_error;
      logic        wall_kept;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  mixing_count;
      logic [31:0] inv_density_0;
      logic [31:0] inv_density_1;
      logic [31:0] inv_density_rest;
      logic [15:0] relax_factor;
      logic [7:0]  wall_type;
      logic        skip_walls;
   } cfg_type;

   // Per-cell data that rides along the divider chain
   typedef struct packed {
      logic [31:0]       old_density;
      logic [PROD_W-1:0] old_prod;
      logic              err;
      logic              wall;
      logic              sat;
   } side_type;

   // One divider stage word
   typedef struct packed {
      logic              valid;
      side_type          side;
      logic [DEN_W-1:0]  d;
      logic [DEN_W-1:0]  r;
      logic [QUO_W-1:0]  nl;
      logic [QUO_W-1:0]  q;
   } div_type;

   // Relax factor clamped to one
   function automatic logic [15:0] clamp_relax(input logic [15:0] relax);
      clamp_relax = (relax > Q15_ONE) ? Q15_ONE : relax;
   endfunction

endpackage

### src/mixture_density_relax.sv
// Top level of the mixture density relaxation pipeline with its register file.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_data  (mdr_pkg::req_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data  (mdr_pkg::rsp_type)
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One word per cycle in and out while the output is not stalled; the pipeline is five front stages,
// the 32-cell restoring divider for the reciprocal and two blend stages.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// The whole pipeline advances while the output register is empty or taken;
// a stalled output freezes every stage and drops req_ready.
// Register writes are always taken (csr_ready high); unknown indexes are ignored.
module mixture_density_relax (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mdr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mdr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);

   mdr_pkg::cfg_type  cfg_ff;
   logic              adv;
   mdr_pkg::div_type  div_chain [mdr_pkg::NUM_DIV_CELLS+1];

   // Move the pipe whenever the output register can take a word
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mixing_count     <= 2'd0;
         cfg_ff.inv_density_0    <= 32'd65536;
         cfg_ff.inv_density_1    <= 32'd65536;
         cfg_ff.inv_density_rest <= 32'd65536;
         cfg_ff.relax_factor     <= mdr_pkg::Q15_ONE;
         cfg_ff.wall_type        <= 8'd0;
         cfg_ff.skip_walls       <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            mdr_pkg::CSR_MIXING_COUNT:     cfg_ff.mixing_count     <= csr_data[1:0];
            mdr_pkg::CSR_INV_DENSITY_0:    cfg_ff.inv_density_0    <= csr_data;
            mdr_pkg::CSR_INV_DENSITY_1:    cfg_ff.inv_density_1    <= csr_data;
            mdr_pkg::CSR_INV_DENSITY_REST: cfg_ff.inv_density_rest <= csr_data;
            mdr_pkg::CSR_RELAX_FACTOR:     cfg_ff.relax_factor     <= csr_data[15:0];
            mdr_pkg::CSR_WALL_TYPE:        cfg_ff.wall_type        <= csr_data[7:0];
            mdr_pkg::CSR_SKIP_WALLS:       cfg_ff.skip_walls       <= csr_data[0];
            default: ;
         endcase
      end
   end

   mdr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .div_out   (div_chain[0])
   );

   // Divider chain, one quotient bit per cell
   for (genvar k = 0; k < mdr_pkg::NUM_DIV_CELLS; k++) begin : g_div
      mdr_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .din   (div_chain[k]),
         .dout  (div_chain[k+1])
      );
   end

   mdr_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .din       (div_chain[mdr_pkg::NUM_DIV_CELLS]),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // No result word right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word present right after reset");

endmodule

### src/mdr_front.sv
// Front stages: weighted inverse density, error and wall flags, divider setup.
module mdr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             req_valid,
   input  mdr_pkg::req_type req_data,
   input  mdr_pkg::cfg_type cfg,
   output mdr_pkg::div_type div_out
);

   logic [1:0]                    used;
   logic                          en0;
   logic                          en1;

   logic                          s1_valid_ff;
   mdr_pkg::req_type              s1_req_ff;
   logic [mdr_pkg::PROD_W-1:0]    s1_p0_ff, s1_p0_in;
   logic [mdr_pkg::FSUM_W-1:0]    s1_fsum_ff, s1_fsum_in;

   logic                          s2_valid_ff;
   mdr_pkg::req_type              s2_req_ff;
   logic [mdr_pkg::PROD_W-1:0]    s2_p0_ff;
   logic [mdr_pkg::PROD_W-1:0]    s2_p1_ff, s2_p1_in;
   logic                          s2_neg_ff, s2_neg_in;
   logic [16:0]                   s2_rmag_ff, s2_rmag_in;

   logic                          s3_valid_ff;
   mdr_pkg::req_type              s3_req_ff;
   logic [mdr_pkg::PROD_W:0]      s3_pos_ff, s3_pos_in;
   logic [mdr_pkg::PROD_W:0]      s3_prest_ff, s3_prest_in;
   logic                          s3_neg_ff;

   logic                          s4_valid_ff;
   logic [mdr_pkg::INV_W-1:0]     s4_inv_ff, s4_inv_in;
   logic [31:0]                   s4_old_ff;
   logic [mdr_pkg::PROD_W-1:0]    s4_oprod_ff, s4_oprod_in;
   logic                          s4_wall_ff, s4_wall_in;
   logic [15:0]                   relax;

   logic                          s5_err;
   logic [mdr_pkg::DEN_W-1:0]     s5_d;
   logic [mdr_pkg::DEN_W-1:0]     s5_n;
   logic                          s5_sat;
   mdr_pkg::div_type              div_ff, div_in;

   // Select the fraction fields in use
   always_comb begin
      used = (32'(cfg.mixing_count) > mdr_pkg::USED_MAX) ?
             2'(mdr_pkg::USED_MAX) : cfg.mixing_count;
      en0  = (used >= 2'd1);
      en1  = (used >= 2'd2);
   end

   // Stage one: stream zero product and fraction sum
   always_comb begin
      s1_p0_in   = en0 ? mdr_pkg::PROD_W'(req_data.mix_frac_0) *
                         mdr_pkg::PROD_W'(cfg.inv_density_0) : '0;
      s1_fsum_in = (en0 ? mdr_pkg::FSUM_W'(req_data.mix_frac_0) : '0) +
                   (en1 ? mdr_pkg::FSUM_W'(req_data.mix_frac_1) : '0);
   end

   // Stage two: stream one product and remainder weight
   always_comb begin
      s2_p1_in   = en1 ? mdr_pkg::PROD_W'(s1_req_ff.mix_frac_1) *
                         mdr_pkg::PROD_W'(cfg.inv_density_1) : '0;
      s2_neg_in  = s1_fsum_ff > mdr_pkg::FSUM_W'(mdr_pkg::Q15_ONE);
      s2_rmag_in = s2_neg_in ? 17'(s1_fsum_ff - mdr_pkg::FSUM_W'(mdr_pkg::Q15_ONE)) :
                               17'(mdr_pkg::FSUM_W'(mdr_pkg::Q15_ONE) - s1_fsum_ff);
   end

   // Stage three: remainder product and positive sum
   always_comb begin
      s3_pos_in   = (mdr_pkg::PROD_W+1)'(s2_p0_ff) + (mdr_pkg::PROD_W+1)'(s2_p1_ff);
      s3_prest_in = (mdr_pkg::PROD_W+1)'(s2_rmag_ff) *
                    (mdr_pkg::PROD_W+1)'(cfg.inv_density_rest);
   end

   // Stage four: signed inverse density, old density weight, wall test
   always_comb begin
      relax       = mdr_pkg::clamp_relax(cfg.relax_factor);
      s4_inv_in   = s3_neg_ff ?
                    mdr_pkg::INV_W'(s3_pos_ff) - mdr_pkg::INV_W'(s3_prest_ff) :
                    mdr_pkg::INV_W'(s3_pos_ff) + mdr_pkg::INV_W'(s3_prest_ff);
      s4_oprod_in = mdr_pkg::PROD_W'(mdr_pkg::Q15_ONE - relax) *
                    mdr_pkg::PROD_W'(s3_req_ff.old_density);
      s4_wall_in  = cfg.skip_walls && (s3_req_ff.cell_kind == cfg.wall_type);
   end

   // Stage five: error flag, rounded numerator, saturation test
   always_comb begin
      s5_err = s4_inv_ff[mdr_pkg::INV_W-1] || (s4_inv_ff == '0);
      s5_d   = s4_inv_ff[mdr_pkg::DEN_W-1:0];
      s5_n   = mdr_pkg::RECIP_NUM + (s5_d >> 1);
      s5_sat = mdr_pkg::DEN_W'(s5_n[mdr_pkg::DEN_W-1:mdr_pkg::QUO_W]) >= s5_d;
      div_in.valid            = s4_valid_ff;
      div_in.side.old_density = s4_old_ff;
      div_in.side.old_prod    = s4_oprod_ff;
      div_in.side.err         = s5_err;
      div_in.side.wall        = s4_wall_ff;
      div_in.side.sat         = s5_sat;
      div_in.d                = s5_d;
      div_in.r                = mdr_pkg::DEN_W'(s5_n[mdr_pkg::DEN_W-1:mdr_pkg::QUO_W]);
      div_in.nl               = s5_n[mdr_pkg::QUO_W-1:0];
      div_in.q                = '0;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_req_ff   <= req_data;
         s1_p0_ff    <= s1_p0_in;
         s1_fsum_ff  <= s1_fsum_in;
         s2_req_ff   <= s1_req_ff;
         s2_p0_ff    <= s1_p0_ff;
         s2_p1_ff    <= s2_p1_in;
         s2_neg_ff   <= s2_neg_in;
         s2_rmag_ff  <= s2_rmag_in;
         s3_req_ff   <= s2_req_ff;
         s3_pos_ff   <= s3_pos_in;
         s3_prest_ff <= s3_prest_in;
         s3_neg_ff   <= s2_neg_ff;
         s4_inv_ff   <= s4_inv_in;
         s4_old_ff   <= s3_req_ff.old_density;
         s4_oprod_ff <= s4_oprod_in;
         s4_wall_ff  <= s4_wall_in;
      end
   end

   // Hand the setup word to the first divider cell
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else if (adv) begin
         div_ff.valid <= div_in.valid;
      end
      if (adv) begin
         div_ff.side <= div_in.side;
         div_ff.d    <= div_in.d;
         div_ff.r    <= div_in.r;
         div_ff.nl   <= div_in.nl;
         div_ff.q    <= div_in.q;
      end
   end

   assign div_out = div_ff;

   // A positive inverse density always hands the divider a nonzero divisor
   a_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      div_ff.valid && !div_ff.side.err |-> div_ff.d != '0)
      else $error("divider entered with zero divisor");

endmodule

### src/mdr_div_cell.sv
// One restoring-division cell: settles one quotient bit and passes the word on.
module mdr_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  mdr_pkg::div_type din,
   output mdr_pkg::div_type dout
);

   logic [mdr_pkg::DEN_W:0]   r_sh;
   logic                      ge;
   mdr_pkg::div_type          dout_ff, dout_in;

   // Shift in the next numerator bit, subtract when it fits
   always_comb begin
      r_sh = {din.r, din.nl[mdr_pkg::QUO_W-1]};
      ge   = r_sh >= {1'b0, din.d};
      dout_in.valid = din.valid;
      dout_in.side  = din.side;
      dout_in.d     = din.d;
      dout_in.r     = ge ? mdr_pkg::DEN_W'(r_sh - {1'b0, din.d}) :
                           r_sh[mdr_pkg::DEN_W-1:0];
      dout_in.nl    = {din.nl[mdr_pkg::QUO_W-2:0], 1'b0};
      dout_in.q     = {din.q[mdr_pkg::QUO_W-2:0], ge};
   end

   // Hand the word to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         dout_ff.valid <= 1'b0;
      end else if (adv) begin
         dout_ff.valid <= dout_in.valid;
      end
      if (adv) begin
         dout_ff.side <= dout_in.side;
         dout_ff.d    <= dout_in.d;
         dout_ff.r    <= dout_in.r;
         dout_ff.nl   <= dout_in.nl;
         dout_ff.q    <= dout_in.q;
      end
   end

   assign dout = dout_ff;

   // Partial remainder stays below the divisor for a live division
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      dout_ff.valid && !dout_ff.side.err && !dout_ff.side.sat |-> dout_ff.r < dout_ff.d)
      else $error("partial remainder not below divisor");

endmodule

### src/mdr_blend.sv
// Back stages: saturate the reciprocal, blend with old density, hold the result word.
module mdr_blend (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  mdr_pkg::div_type din,
   input  mdr_pkg::cfg_type cfg,
   output logic             rsp_valid,
   output mdr_pkg::rsp_type rsp_data
);

   logic [15:0]                 relax;
   logic [31:0]                 recip_den;
   logic                        b1_valid_ff;
   mdr_pkg::side_type           b1_side_ff;
   logic [mdr_pkg::PROD_W-1:0]  b1_prod_ff, b1_prod_in;

   logic [mdr_pkg::PROD_W:0]    acc;
   logic [33:0]                 blend;
   logic [31:0]                 blend_sat;
   logic                        rsp_valid_ff;
   mdr_pkg::rsp_type            rsp_ff, rsp_in;

   // Weight the local density by the relax factor
   always_comb begin
      relax      = mdr_pkg::clamp_relax(cfg.relax_factor);
      recip_den  = din.side.sat ? '1 : din.q;
      b1_prod_in = mdr_pkg::PROD_W'(relax) * mdr_pkg::PROD_W'(recip_den);
   end

   // Sum, round, saturate, and pick old density on error or wall
   always_comb begin
      acc       = (mdr_pkg::PROD_W+1)'(b1_prod_ff) +
                  (mdr_pkg::PROD_W+1)'(b1_side_ff.old_prod) +
                  (mdr_pkg::PROD_W+1)'(mdr_pkg::ROUND_HALF);
      blend     = acc[mdr_pkg::PROD_W:15];
      blend_sat = (|blend[33:32]) ? '1 : blend[31:0];
      rsp_in.relaxed_den   = (b1_side_ff.err || b1_side_ff.wall) ?
                             b1_side_ff.old_density : blend_sat;
      rsp_in.density_error = b1_side_ff.err;
      rsp_in.wall_kept     = b1_side_ff.wall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff  <= din.valid;
         rsp_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_side_ff <= din.side;
         b1_prod_ff <= b1_prod_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A word in the last stage reaches the output register when the pipe moves
   a_b1_to_out: assert property (@(posedge clock) disable iff (reset)
      adv && b1_valid_ff |=> rsp_valid_ff)
      else $error("word lost between blend stage and output");

endmodule
